>>> rtl/rslh_pkg.sv
// ----------------------------------------------------------------------------
// rslh_pkg: shared types and constants for the running statistics monitor
// Holds the request codes, field widths and the histogram control word.
// ----------------------------------------------------------------------------
`default_nettype none

package rslh_pkg;

    localparam int NUM_BINS_DEF = 16;
    localparam int VAL_W        = 64;
    localparam int SEL_W        = 4;
    // highest-set-bit position plus one: 0..64
    localparam int POS_W        = 7;

    typedef enum logic {
        REQ_ADD  = 1'b0,
        REQ_READ = 1'b1
    } req_t;

    // histogram update/read for one item
    typedef struct packed {
        logic             upd;
        logic [POS_W-1:0] pos;
        logic [SEL_W-1:0] sel;
    } hist_ctrl_t;

    // 0 for zero, else index of the highest set bit plus one
    function automatic logic [POS_W-1:0] bit_pos(input logic [VAL_W-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < VAL_W; i++) begin
            if (v[i]) begin
                p = POS_W'(i + 1);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

>>> rtl/running_stats_log2_histogram.sv
// ----------------------------------------------------------------------------
// running_stats_log2_histogram: running statistics with a log2 histogram
// Usage:
//   Input stream s_*: tuser is the request (0 add sample, 1 read only),
//   tdata holds the sample value and the bin to report.
//   Output stream m_*: one word per input word with count, sum, sum of
//   squares, min, max and the selected bin's count after that word.
//   An input word passes through an input register, a stage holding the
//   two 32x32 partial products of the square and the bin position, and
//   the result register where all accumulators update together.
//   Throughput is one word per cycle while the receiver does not stall;
//   the accumulator feedback closes in the last stage.
//   A stalled receiver holds the result register; the stages behind it
//   keep filling and s_tready drops only once all three are occupied.
//   Reset (aresetn low, synchronous) clears all totals, all bins and all
//   pipeline valid bits; min and max read 0 until the first sample.
// ----------------------------------------------------------------------------
`default_nettype none

module running_stats_log2_histogram #(
    parameter int NUM_BINS = rslh_pkg::NUM_BINS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [71:0]  s_tdata,   // sample_value[63:0], bin_select[67:64]
    input  wire logic         s_tuser,   // req_type
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // sample_count, value_sum, square_sum, min_value, max_value, bin_count
    output logic [383:0]      m_tdata
);
    import rslh_pkg::*;

    localparam int HALF_W = VAL_W / 2;

    // stage A: input register
    logic             a_valid_reg;
    logic             a_req_reg;
    logic [VAL_W-1:0] a_val_reg;
    logic [SEL_W-1:0] a_sel_reg;

    // stage B: partial products and bin position
    logic              b_valid_reg;
    logic              b_req_reg;
    logic [VAL_W-1:0]  b_val_reg;
    logic [SEL_W-1:0]  b_sel_reg;
    logic [VAL_W-1:0]  b_ll_reg;
    logic [HALF_W-1:0] b_hl_reg;
    logic [POS_W-1:0]  b_pos_reg;

    // running totals
    logic [VAL_W-1:0] count_reg, count_next;
    logic [VAL_W-1:0] sum_reg, sum_next;
    logic [VAL_W-1:0] sq_reg, sq_next;
    logic [VAL_W-1:0] min_reg, min_next;
    logic [VAL_W-1:0] max_reg, max_next;

    logic [VAL_W-1:0] bin_count;
    hist_ctrl_t       hctrl;
    logic             m_valid_reg;
    logic [383:0]     m_data_reg;

    logic a_adv, b_adv, m_load, do_add;
    logic [VAL_W-1:0] a_lo, a_hi;

    assign m_load   = !m_valid_reg || m_tready;
    assign b_adv    = !b_valid_reg || m_load;
    assign a_adv    = !a_valid_reg || b_adv;
    assign s_tready = a_adv;

    assign a_lo = VAL_W'(a_val_reg[HALF_W-1:0]);
    assign a_hi = VAL_W'(a_val_reg[VAL_W-1:HALF_W]);

    assign do_add = b_valid_reg && m_load && (b_req_reg == REQ_ADD);

    // v*v mod 2^64 = lo*lo + (hi*lo << 33)
    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        sq_next    = sq_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        if (do_add) begin
            count_next = count_reg + VAL_W'(1);
            sum_next   = sum_reg + b_val_reg;
            sq_next    = sq_reg + b_ll_reg + {b_hl_reg[HALF_W-2:0], {(HALF_W+1){1'b0}}};
            // first sample after reset or count wrap loads both
            if (count_reg == '0 || b_val_reg < min_reg) begin
                min_next = b_val_reg;
            end
            if (count_reg == '0 || b_val_reg > max_reg) begin
                max_next = b_val_reg;
            end
        end
    end

    assign hctrl.upd = do_add;
    assign hctrl.pos = b_pos_reg;
    assign hctrl.sel = b_sel_reg;

    rslh_hist #(
        .NUM_BINS (NUM_BINS)
    ) u_hist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (hctrl),
        .bin_count (bin_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            min_reg     <= '0;
            max_reg     <= '0;
        end else begin
            if (a_adv) begin
                a_valid_reg <= s_tvalid;
            end
            if (b_adv) begin
                b_valid_reg <= a_valid_reg;
            end
            if (m_load) begin
                m_valid_reg <= b_valid_reg;
            end
            count_reg <= count_next;
            sum_reg   <= sum_next;
            sq_reg    <= sq_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (a_adv && s_tvalid) begin
            a_req_reg <= s_tuser;
            a_val_reg <= s_tdata[VAL_W-1:0];
            a_sel_reg <= s_tdata[VAL_W+SEL_W-1:VAL_W];
        end
        if (b_adv && a_valid_reg) begin
            b_req_reg <= a_req_reg;
            b_val_reg <= a_val_reg;
            b_sel_reg <= a_sel_reg;
            b_ll_reg  <= a_lo * a_lo;
            b_hl_reg  <= HALF_W'(a_hi * a_lo);
            b_pos_reg <= bit_pos(a_val_reg);
        end
        if (m_load && b_valid_reg) begin
            m_data_reg <= {bin_count, max_next, min_next, sq_next, sum_next, count_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

>>> rtl/rslh_hist.sv
// ----------------------------------------------------------------------------
// rslh_hist: log2 histogram counters
// One 64-bit counter per bin; increments the bin of a sample and returns
// the selected bin's count including this cycle's update.
// ----------------------------------------------------------------------------
`default_nettype none

module rslh_hist #(
    parameter int NUM_BINS = rslh_pkg::NUM_BINS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire rslh_pkg::hist_ctrl_t       ctrl,
    output logic [rslh_pkg::VAL_W-1:0]      bin_count
);
    import rslh_pkg::*;

    localparam logic [POS_W-1:0] LAST_BIN = POS_W'(NUM_BINS - 1);
    localparam logic [POS_W-1:0] BIN_LIM  = POS_W'(NUM_BINS);

    logic [VAL_W-1:0] cnt_reg [NUM_BINS];
    logic [POS_W-1:0] bin;
    logic [POS_W-1:0] sel;
    logic [VAL_W-1:0] rd;
    logic             hit;

    // large samples collapse into the last bin
    assign bin = (ctrl.pos >= LAST_BIN) ? LAST_BIN : ctrl.pos;
    assign sel = POS_W'(ctrl.sel);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_BINS; i++) begin
            if (!aresetn) begin
                cnt_reg[i] <= '0;
            end else if (ctrl.upd && bin == POS_W'(i)) begin
                cnt_reg[i] <= cnt_reg[i] + VAL_W'(1);
            end
        end
    end

    always_comb begin
        rd = '0;
        for (int i = 0; i < NUM_BINS; i++) begin
            if (sel == POS_W'(i)) begin
                rd = cnt_reg[i];
            end
        end
        hit = ctrl.upd && (bin == sel);
        bin_count = (sel < BIN_LIM) ? (rd + VAL_W'(hit)) : '0;
    end

endmodule

`default_nettype wire

>>> verif/tb_running_stats_log2_histogram.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_running_stats_log2_histogram: self-checking bench for the stats monitor
// Drives sample and read words on the input stream and keeps its own copy of
// the totals and the log2 histogram. Every result word is checked field by
// field against the oldest prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb_running_stats_log2_histogram;

    import rslh_pkg::*;

    localparam int BINS = 16;

    // result fields, sample_count in the lowest bits as on m_tdata
    typedef struct packed {
        logic [63:0] bin_count;
        logic [63:0] max_value;
        logic [63:0] min_value;
        logic [63:0] square_sum;
        logic [63:0] value_sum;
        logic [63:0] sample_count;
    } stats_result_t;

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [71:0]   s_tdata  = '0;   // sample_value[63:0], bin_select[67:64]
    logic          s_tuser  = 1'b0; // req_type
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [383:0]  m_tdata;         // sample_count, value_sum, square_sum,
                                    // min_value, max_value, bin_count

    running_stats_log2_histogram DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shadow totals
    logic [63:0] num_samples;
    logic [63:0] total;
    logic [63:0] total_sq;
    logic [63:0] lowest;
    logic [63:0] highest;
    logic [63:0] hist [BINS];

    stats_result_t totals_due[$];
    string         field_name [6] = '{"sample_count", "value_sum", "square_sum",
                                      "min_value", "max_value", "bin_count"};

    int          errors      = 0;
    int          words_seen  = 0;
    int          adds_sent   = 0;
    int          reads_sent  = 0;
    bit          pacing_on   = 1'b0;
    int unsigned stall_left  = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout, %0d results still due", $time, totals_due.size());
        $display("FAILED: results differ");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic int unsigned log2_bin(logic [63:0] v);
        int unsigned b;
        b = 0;
        for (int i = 63; i >= 0; i--) begin
            if (v[i] && b == 0) begin
                b = i + 1;
            end
        end
        return (b > BINS - 1) ? BINS - 1 : b;
    endfunction

    // applies one word to the shadow totals and returns the expected result
    function automatic stats_result_t stats_update(req_t req, logic [63:0] v,
                                                   logic [3:0] sel);
        stats_result_t r;
        if (req == REQ_ADD) begin
            if (num_samples == 0) begin
                lowest  = v;
                highest = v;
            end
            num_samples = num_samples + 64'd1;
            total       = total + v;
            total_sq    = total_sq + v * v;
            if (v < lowest) begin
                lowest = v;
            end
            if (v > highest) begin
                highest = v;
            end
            hist[log2_bin(v)] = hist[log2_bin(v)] + 64'd1;
        end
        r.sample_count = num_samples;
        r.value_sum    = total;
        r.square_sum   = total_sq;
        r.min_value    = lowest;
        r.max_value    = highest;
        r.bin_count    = (sel < BINS) ? hist[sel] : 64'd0;
        return r;
    endfunction

    task automatic send_word(req_t req, logic [63:0] v, logic [3:0] sel);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0, sel, v};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        totals_due.push_back(stats_update(req, v, sel));
        if (req == REQ_ADD) begin
            adds_sent++;
        end else begin
            reads_sent++;
        end
        if (pacing_on && $urandom_range(0, 2) == 0) begin
            gap = pick_gap();
            s_tvalid <= 1'b0;
            s_tdata  <= 72'({$urandom, $urandom, $urandom});
            repeat (gap) @(posedge aclk);
        end
    endtask

    // values spread over all bit lengths so every bin fills
    function automatic logic [63:0] rand_sample();
        logic [63:0] v;
        int unsigned w;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = v;
            default: begin
                w = $urandom_range(1, 64);
                v = (w == 64) ? v : (v & ((64'd1 << w) - 64'd1));
                v[w-1] = 1'b1;
            end
        endcase
        return v;
    endfunction

    // result checker
    initial begin
        stats_result_t exp;
        logic [383:0]  flat;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                words_seen++;
                if (totals_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, m_tdata);
                end else begin
                    exp  = totals_due.pop_front();
                    flat = exp;
                    for (int i = 0; i < 6; i++) begin
                        if (m_tdata[64*i +: 64] !== flat[64*i +: 64]) begin
                            errors++;
                            $display("%0t: %s expected %h got %h", $time,
                                     field_name[i], flat[64*i +: 64],
                                     m_tdata[64*i +: 64]);
                        end
                    end
                end
            end
        end
    end

    // receiver stalls
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (pacing_on && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // min and max must read zero before the first sample
    task automatic test_empty_reads();
        send_word(REQ_READ, '1, 4'd0);
        send_word(REQ_READ, {$urandom, $urandom}, 4'd15);
    endtask

    // bin boundaries, clamp into the last bin, extremes of the value range
    task automatic test_bin_edges();
        logic [63:0] edge_vals [10] = '{64'd1000, 64'd0, '1, 64'd1, 64'd2,
                                        64'd3, 64'h3FFF, 64'h4000, 64'h7FFF,
                                        64'h8000_0000_0000_0000};
        foreach (edge_vals[i]) begin
            send_word(REQ_ADD, edge_vals[i], 4'($urandom));
        end
        // reads ignore the value field
        for (int b = 0; b < BINS; b += 2) begin
            send_word(REQ_READ, {$urandom, $urandom}, 4'(b));
        end
        send_word(REQ_READ, '1, 4'd15);
    endtask

    // full rate on both sides
    task automatic test_back_to_back(int n);
        pacing_on = 1'b0;
        for (int i = 0; i < n; i++) begin
            send_word(($urandom_range(0, 4) == 0) ? REQ_READ : REQ_ADD,
                      rand_sample(), 4'($urandom));
        end
    endtask

    task automatic test_random_traffic(int n);
        for (int i = 0; i < n; i++) begin
            // two paced stretches, then one unpaced stretch, repeating
            if (i % 100 == 0) begin
                pacing_on = (i % 300 != 200);
            end
            send_word(($urandom_range(0, 4) == 0) ? REQ_READ : REQ_ADD,
                      rand_sample(), 4'($urandom));
        end
        pacing_on = 1'b0;
    endtask

    initial begin
        num_samples = '0;
        total       = '0;
        total_sq    = '0;
        lowest      = '0;
        highest     = '0;
        foreach (hist[i]) begin
            hist[i] = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        pacing_on = 1'b1;
        test_empty_reads();
        test_bin_edges();
        test_back_to_back(100);
        test_random_traffic(580);

        s_tvalid <= 1'b0;
        while (totals_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        $display("Checked %0d result words: %0d samples over all %0d bins, %0d reads,",
                 words_seen, adds_sent, BINS, reads_sent);
        $display("with random stalls on both streams and full-rate stretches.");
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> running_stats_log2_histogram.f
rtl/rslh_pkg.sv
rtl/rslh_hist.sv
rtl/running_stats_log2_histogram.sv
verif/tb_running_stats_log2_histogram.sv
